>>> design/ccc_pkg.sv
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared widths, constants and types of the circumcircle circumference pipe.
// ----------------------------------------------------------------------------
package ccc_pkg;

	localparam int COORD_W   = 32;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD_W    = 2 * DIFF_W;
	localparam int GEO_W     = PROD_W + 1;
	localparam int OUT_W     = 40;
	localparam int FRAC_DEF  = 8;
	localparam int PI_FRAC   = 60;

	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

	// (200 * pi) squared, pi in 60 fraction bits
	localparam int KC_W = 140;
	localparam logic [KC_W-1:0] K_LIN = KC_W'(200) * KC_W'(PI_Q60);
	localparam logic [KC_W-1:0] K_SQ  = K_LIN * K_LIN;

	localparam int SQ3_W  = 3 * GEO_W;
	localparam int RHS_W  = SQ3_W + KC_W;
	localparam int RIN_W  = RHS_W + (RHS_W % 2);
	localparam int ROOT_W = RIN_W / 2;

	localparam logic [OUT_W-1:0] OUT_MAX = '1;

	typedef struct packed {
		logic [GEO_W-1:0] dmag;
		logic [GEO_W-1:0] a2;
		logic [GEO_W-1:0] b2;
		logic [GEO_W-1:0] c2;
	} geo_t;

endpackage

>>> design/ccc_front.sv
// ----------------------------------------------------------------------------
// ccc_front
// Edge vectors, cross products and squared side lengths, three stages.
// ----------------------------------------------------------------------------
module ccc_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic signed [ccc_pkg::COORD_W-1:0]  first_x,
	input  logic signed [ccc_pkg::COORD_W-1:0]  first_y,
	input  logic signed [ccc_pkg::COORD_W-1:0]  second_x,
	input  logic signed [ccc_pkg::COORD_W-1:0]  second_y,
	input  logic signed [ccc_pkg::COORD_W-1:0]  third_x,
	input  logic signed [ccc_pkg::COORD_W-1:0]  third_y,
	output logic                                out_valid,
	output ccc_pkg::geo_t                       geo
);
	import ccc_pkg::*;

	logic               v_s1, v_s2, v_s3;
	logic signed [DIFF_W-1:0] ux_s1, uy_s1, vx_s1, vy_s1, wx_s1, wy_s1;
	logic signed [PROD_W-1:0] p1_s2, p2_s2;
	logic signed [PROD_W-1:0] uxx_s2, uyy_s2, vxx_s2, vyy_s2, wxx_s2, wyy_s2;
	logic signed [GEO_W-1:0]  d_diff;
	geo_t                     geo_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign d_diff = GEO_W'(p1_s2) - GEO_W'(p2_s2);

	always_ff @(posedge clk) begin
		ux_s1 <= DIFF_W'(second_x) - DIFF_W'(first_x);
		uy_s1 <= DIFF_W'(second_y) - DIFF_W'(first_y);
		vx_s1 <= DIFF_W'(third_x) - DIFF_W'(first_x);
		vy_s1 <= DIFF_W'(third_y) - DIFF_W'(first_y);
		wx_s1 <= DIFF_W'(third_x) - DIFF_W'(second_x);
		wy_s1 <= DIFF_W'(third_y) - DIFF_W'(second_y);

		p1_s2  <= PROD_W'(ux_s1) * PROD_W'(vy_s1);
		p2_s2  <= PROD_W'(uy_s1) * PROD_W'(vx_s1);
		uxx_s2 <= PROD_W'(ux_s1) * PROD_W'(ux_s1);
		uyy_s2 <= PROD_W'(uy_s1) * PROD_W'(uy_s1);
		vxx_s2 <= PROD_W'(vx_s1) * PROD_W'(vx_s1);
		vyy_s2 <= PROD_W'(vy_s1) * PROD_W'(vy_s1);
		wxx_s2 <= PROD_W'(wx_s1) * PROD_W'(wx_s1);
		wyy_s2 <= PROD_W'(wy_s1) * PROD_W'(wy_s1);

		geo_s3.dmag <= d_diff[GEO_W-1] ? GEO_W'(-d_diff) : GEO_W'(d_diff);
		geo_s3.a2   <= GEO_W'(uxx_s2[PROD_W-1:0]) + GEO_W'(uyy_s2[PROD_W-1:0]);
		geo_s3.b2   <= GEO_W'(wxx_s2[PROD_W-1:0]) + GEO_W'(wyy_s2[PROD_W-1:0]);
		geo_s3.c2   <= GEO_W'(vxx_s2[PROD_W-1:0]) + GEO_W'(vyy_s2[PROD_W-1:0]);
	end

	assign out_valid = v_s3;
	assign geo       = geo_s3;

endmodule

>>> design/ccc_mul.sv
// ----------------------------------------------------------------------------
// ccc_mul
// Wide multiplier, one 32x32 partial product accumulated per stage.
// ----------------------------------------------------------------------------
module ccc_mul #(
	parameter int A_W    = 67,
	parameter int B_W    = 67,
	parameter int SIDE_W = 67
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	input  logic [SIDE_W-1:0]  side,
	output logic               out_valid,
	output logic [A_W+B_W-1:0] p,
	output logic [SIDE_W-1:0]  side_out
);
	localparam int NA    = (A_W + 31) / 32;
	localparam int NB    = (B_W + 31) / 32;
	localparam int N     = NA * NB;
	localparam int AP_W  = NA * 32;
	localparam int BP_W  = NB * 32;
	localparam int ACC_W = AP_W + BP_W;

	logic [N-1:0]      v_s;
	logic [AP_W-1:0]   a_s    [N];
	logic [BP_W-1:0]   b_s    [N];
	logic [ACC_W-1:0]  acc_s  [N];
	logic [SIDE_W-1:0] side_s [N];

	for (genvar k = 0; k < N; k++) begin : g_st
		localparam int I = k / NB;
		localparam int J = k % NB;
		logic              v_in;
		logic [AP_W-1:0]   a_in;
		logic [BP_W-1:0]   b_in;
		logic [ACC_W-1:0]  acc_in;
		logic [SIDE_W-1:0] side_in;
		logic [63:0]       pp;

		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign a_in    = AP_W'(a);
			assign b_in    = BP_W'(b);
			assign acc_in  = '0;
			assign side_in = side;
		end else begin : g_next
			assign v_in    = v_s[k-1];
			assign a_in    = a_s[k-1];
			assign b_in    = b_s[k-1];
			assign acc_in  = acc_s[k-1];
			assign side_in = side_s[k-1];
		end

		assign pp = 64'(a_in[I*32 +: 32]) * 64'(b_in[J*32 +: 32]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			a_s[k]    <= a_in;
			b_s[k]    <= b_in;
			side_s[k] <= side_in;
			acc_s[k]  <= acc_in + (ACC_W'(pp) << (32 * (I + J)));
		end
	end

	assign out_valid = v_s[N-1];
	assign p         = acc_s[N-1][A_W+B_W-1:0];
	assign side_out  = side_s[N-1];

endmodule

>>> design/ccc_isqrt.sv
// ----------------------------------------------------------------------------
// ccc_isqrt
// Integer square root, restoring method, one root bit per stage.
// ----------------------------------------------------------------------------
module ccc_isqrt #(
	parameter int IN_W   = 342,
	parameter int SIDE_W = 67
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [IN_W-1:0]     x,
	input  logic [SIDE_W-1:0]   side,
	output logic                out_valid,
	output logic [IN_W/2-1:0]   root,
	output logic [SIDE_W-1:0]   side_out
);
	localparam int N   = IN_W / 2;
	localparam int R_W = N + 2;

	logic [N-1:0]      v_s;
	logic [IN_W-1:0]   x_s    [N];
	logic [R_W-1:0]    rem_s  [N];
	logic [N-1:0]      root_s [N];
	logic [SIDE_W-1:0] side_s [N];

	for (genvar k = 0; k < N; k++) begin : g_st
		logic              v_in;
		logic [IN_W-1:0]   x_in;
		logic [R_W-1:0]    rem_in;
		logic [N-1:0]      root_in;
		logic [SIDE_W-1:0] side_in;
		logic [R_W-1:0]    rem_sh;
		logic [R_W-1:0]    trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign x_in    = x;
			assign rem_in  = '0;
			assign root_in = '0;
			assign side_in = side;
		end else begin : g_next
			assign v_in    = v_s[k-1];
			assign x_in    = x_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign side_in = side_s[k-1];
		end

		assign rem_sh = {rem_in[N-1:0], x_in[IN_W-1 -: 2]};
		assign trial  = {root_in, 2'b01};
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			x_s[k]    <= x_in << 2;
			rem_s[k]  <= ge ? rem_sh - trial : rem_sh;
			root_s[k] <= {root_in[N-2:0], ge};
			side_s[k] <= side_in;
		end
	end

	assign out_valid = v_s[N-1];
	assign root      = root_s[N-1];
	assign side_out  = side_s[N-1];

endmodule

>>> design/ccc_div.sv
// ----------------------------------------------------------------------------
// ccc_div
// Unsigned divider, restoring method, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ccc_div #(
	parameter int N_W = 171,
	parameter int D_W = 67
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	output logic           out_valid,
	output logic [N_W-1:0] quot,
	output logic [D_W-1:0] den_out
);
	logic [N_W-1:0] v_s;
	logic [N_W-1:0] n_s   [N_W];
	logic [N_W-1:0] q_s   [N_W];
	logic [D_W-1:0] rem_s [N_W];
	logic [D_W-1:0] d_s   [N_W];

	for (genvar k = 0; k < N_W; k++) begin : g_st
		logic           v_in;
		logic [N_W-1:0] n_in;
		logic [N_W-1:0] q_in;
		logic [D_W-1:0] rem_in;
		logic [D_W-1:0] d_in;
		logic [D_W:0]   rem_sh;
		logic [D_W:0]   rem_dn;
		logic           ge;

		if (k == 0) begin : g_first
			assign v_in   = in_valid;
			assign n_in   = num;
			assign q_in   = '0;
			assign rem_in = '0;
			assign d_in   = den;
		end else begin : g_next
			assign v_in   = v_s[k-1];
			assign n_in   = n_s[k-1];
			assign q_in   = q_s[k-1];
			assign rem_in = rem_s[k-1];
			assign d_in   = d_s[k-1];
		end

		assign rem_sh = {rem_in, n_in[N_W-1]};
		assign ge     = rem_sh >= {1'b0, d_in};
		assign rem_dn = ge ? rem_sh - {1'b0, d_in} : rem_sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			n_s[k]   <= n_in << 1;
			q_s[k]   <= {q_in[N_W-2:0], ge};
			rem_s[k] <= rem_dn[D_W-1:0];
			d_s[k]   <= d_in;
		end
	end

	assign out_valid = v_s[N_W-1];
	assign quot      = q_s[N_W-1];
	assign den_out   = d_s[N_W-1];

endmodule

>>> design/circumcircle_circumference_top.sv
// ----------------------------------------------------------------------------
// circumcircle_circumference_top
// Circumference of the circle through three points, in hundredths.
// ----------------------------------------------------------------------------
// usage:
//   a beat is taken on a rising edge with start high and busy low; busy is
//   always low, so a new point triple can enter every cycle
//   each beat gives one result beat: done is high for exactly one cycle with
//   circumference_hundredths, degenerate and saturated valid alongside
//   results leave in the order the beats entered
//   the pipe holds 3 front stages, 9 + 15 + 35 stages of 32x32
//   partial products, 171 square-root stages, 171 divider stages and the
//   output register; the bit-per-stage root and divide set the depth
//   throughput is one beat per cycle
//   collinear or coincident points give 0 with degenerate set; a value above
//   the 40-bit range gives all ones with saturated set
//   reset clears all valid bits, so no result beat appears after reset until
//   a new beat is taken
//   the receiver has no way to stall, done is never held off
// ----------------------------------------------------------------------------
module circumcircle_circumference_top #(
	parameter int COORD_FRAC_BITS = ccc_pkg::FRAC_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [ccc_pkg::COORD_W-1:0] first_x,
	input  logic signed [ccc_pkg::COORD_W-1:0] first_y,
	input  logic signed [ccc_pkg::COORD_W-1:0] second_x,
	input  logic signed [ccc_pkg::COORD_W-1:0] second_y,
	input  logic signed [ccc_pkg::COORD_W-1:0] third_x,
	input  logic signed [ccc_pkg::COORD_W-1:0] third_y,
	output logic                               done,
	output logic [ccc_pkg::OUT_W-1:0]          circumference_hundredths,
	output logic                               degenerate,
	output logic                               saturated
);
	import ccc_pkg::*;

	localparam int SH = COORD_FRAC_BITS + PI_FRAC;

	logic                   geo_v;
	geo_t                   geo;
	logic                   m1_v, m2_v, m3_v, rt_v, dv_v;
	logic [2*GEO_W-1:0]     m1_p;
	logic [2*GEO_W-1:0]     m1_side;
	logic [SQ3_W-1:0]       m2_p;
	logic [GEO_W-1:0]       m2_side;
	logic [RHS_W-1:0]       m3_p;
	logic [GEO_W-1:0]       m3_side;
	logic [ROOT_W-1:0]      rt_root;
	logic [GEO_W-1:0]       rt_side;
	logic [ROOT_W-1:0]      dv_q;
	logic [GEO_W-1:0]       dv_d;
	logic [ROOT_W-1:0]      qs;
	logic [OUT_W:0]         q_lo;
	logic                   q_sat;
	logic [OUT_W+1:0]       q_rnd;

	logic                   done_q;
	logic [OUT_W-1:0]       circ_q;
	logic                   deg_q;
	logic                   sat_q;

	assign busy = 1'b0;

	ccc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.first_x   (first_x),
		.first_y   (first_y),
		.second_x  (second_x),
		.second_y  (second_y),
		.third_x   (third_x),
		.third_y   (third_y),
		.out_valid (geo_v),
		.geo       (geo)
	);

	ccc_mul #(.A_W(GEO_W), .B_W(GEO_W), .SIDE_W(2*GEO_W)) u_mul_ab (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (geo_v),
		.a         (geo.a2),
		.b         (geo.b2),
		.side      ({geo.c2, geo.dmag}),
		.out_valid (m1_v),
		.p         (m1_p),
		.side_out  (m1_side)
	);

	ccc_mul #(.A_W(2*GEO_W), .B_W(GEO_W), .SIDE_W(GEO_W)) u_mul_abc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (m1_v),
		.a         (m1_p),
		.b         (m1_side[2*GEO_W-1:GEO_W]),
		.side      (m1_side[GEO_W-1:0]),
		.out_valid (m2_v),
		.p         (m2_p),
		.side_out  (m2_side)
	);

	ccc_mul #(.A_W(SQ3_W), .B_W(KC_W), .SIDE_W(GEO_W)) u_mul_k (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (m2_v),
		.a         (m2_p),
		.b         (K_SQ),
		.side      (m2_side),
		.out_valid (m3_v),
		.p         (m3_p),
		.side_out  (m3_side)
	);

	ccc_isqrt #(.IN_W(RIN_W), .SIDE_W(GEO_W)) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (m3_v),
		.x         (RIN_W'(m3_p)),
		.side      (m3_side),
		.out_valid (rt_v),
		.root      (rt_root),
		.side_out  (rt_side)
	);

	ccc_div #(.N_W(ROOT_W), .D_W(GEO_W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rt_v),
		.num       (rt_root),
		.den       (rt_side),
		.out_valid (dv_v),
		.quot      (dv_q),
		.den_out   (dv_d)
	);

	// round half up: n = (q + 1) / 2
	assign qs    = dv_q >> SH;
	assign q_lo  = qs[OUT_W:0];
	assign q_sat = (|qs[ROOT_W-1:OUT_W+1]) || (&q_lo);
	assign q_rnd = (OUT_W+2)'(q_lo) + (OUT_W+2)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (dv_d == '0) begin
			circ_q <= '0;
			deg_q  <= 1'b1;
			sat_q  <= 1'b0;
		end else if (q_sat) begin
			circ_q <= OUT_MAX;
			deg_q  <= 1'b0;
			sat_q  <= 1'b1;
		end else begin
			circ_q <= q_rnd[OUT_W:1];
			deg_q  <= 1'b0;
			sat_q  <= 1'b0;
		end
	end

	assign done                     = done_q;
	assign circumference_hundredths = circ_q;
	assign degenerate               = deg_q;
	assign saturated                = sat_q;

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the circumcircle circumference pipe: point triples
// are driven with random gaps, every beat is predicted with exact wide integer
// arithmetic, and each done beat is checked in order against the prediction.
// ----------------------------------------------------------------------------
module tb;

	import ccc_pkg::*;

	localparam int FRAC      = FRAC_DEF;
	localparam int BW        = 420;
	localparam int LATENCY   = 405;
	localparam int IDLE_MAX  = 20000;
	localparam int N_RANDOM  = 750;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct {
		logic [OUT_W-1:0] circ;
		logic             degen;
		logic             sat;
	} circ_res_t;

	class circ_scoreboard;
		circ_res_t pending[$];
		int        errors = 0;

		function automatic logic [BW-1:0] sq_len(logic signed [BW-1:0] dx,
			logic signed [BW-1:0] dy);
			return dx * dx + dy * dy;
		endfunction

		function automatic circ_res_t predict(coord_t c[6]);
			logic signed [BW-1:0] x1, y1, x2, y2, x3, y3, d;
			logic [BW-1:0] dmag, base, rhs, k, t;
			logic [63:0] lo, hi, mid;
			circ_res_t r;
			x1 = c[0]; y1 = c[1]; x2 = c[2]; y2 = c[3]; x3 = c[4]; y3 = c[5];
			d = (x2 - x1) * (y3 - y1) - (y2 - y1) * (x3 - x1);
			dmag = d < 0 ? -d : d;
			r.circ = '0; r.degen = 1'b0; r.sat = 1'b0;
			if (dmag == 0) begin
				r.degen = 1'b1;
				return r;
			end
			k = BW'(200) * BW'(PI_Q60);
			rhs = k * k * sq_len(x2 - x1, y2 - y1) * sq_len(x3 - x2, y3 - y2)
				* sq_len(x3 - x1, y3 - y1);
			base = dmag << (FRAC + PI_FRAC);
			lo = 0;
			hi = 64'(OUT_MAX) + 1;
			while (lo < hi) begin
				mid = lo + (hi - lo + 1) / 2;
				t = BW'(2 * mid - 1) * base;
				if (t * t <= rhs) lo = mid;
				else hi = mid - 1;
			end
			if (lo > 64'(OUT_MAX)) begin
				r.circ = OUT_MAX;
				r.sat = 1'b1;
			end else begin
				r.circ = lo[OUT_W-1:0];
			end
			return r;
		endfunction

		function void note_beat(coord_t c[6]);
			pending.push_back(predict(c));
		endfunction

		function void check_beat(circ_res_t got);
			circ_res_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result circ=%0d degen=%0b sat=%0b", $time,
					got.circ, got.degen, got.sat);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.circ !== want.circ) begin
				$display("%0t: circumference expected %0d actual %0d", $time,
					want.circ, got.circ);
				errors++;
			end
			if (got.degen !== want.degen) begin
				$display("%0t: degenerate expected %0b actual %0b", $time,
					want.degen, got.degen);
				errors++;
			end
			if (got.sat !== want.sat) begin
				$display("%0t: saturated expected %0b actual %0b", $time,
					want.sat, got.sat);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, done, degenerate, saturated;
	coord_t first_x, first_y, second_x, second_y, third_x, third_y;
	logic [OUT_W-1:0] circumference_hundredths;

	circ_scoreboard sb = new();
	int idle_cycles = 0;

	circumcircle_circumference_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.first_x(first_x), .first_y(first_y), .second_x(second_x),
		.second_y(second_y), .third_x(third_x), .third_y(third_y),
		.done(done), .circumference_hundredths(circumference_hundredths),
		.degenerate(degenerate), .saturated(saturated)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// input beat and result beat capture, idle watchdog
	always @(posedge clk) begin
		coord_t c[6];
		circ_res_t got;
		if (arst_n && start && !busy) begin
			c[0] = first_x; c[1] = first_y; c[2] = second_x;
			c[3] = second_y; c[4] = third_x; c[5] = third_y;
			sb.note_beat(c);
		end
		if (arst_n && done) begin
			got.circ = circumference_hundredths;
			got.degen = degenerate;
			got.sat = saturated;
			sb.check_beat(got);
		end
		if (arst_n && !(start && !busy) && !done) idle_cycles++;
		else idle_cycles = 0;
		if (idle_cycles >= IDLE_MAX) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send(coord_t x1, coord_t y1, coord_t x2, coord_t y2,
		coord_t x3, coord_t y3);
		@(negedge clk);
		first_x <= x1; first_y <= y1; second_x <= x2;
		second_y <= y2; third_x <= x3; third_y <= y3;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause(int n);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 500);
	endfunction

	function automatic coord_t small_coord();
		return coord_t'($signed($urandom_range(0, 8191)) - 4096);
	endfunction

	initial begin
		coord_t mx, mn, ax, ay, dx, dy;
		int k, m, mode, burst;
		mx = 32'sh7FFFFFFF;
		mn = 32'sh80000000;
		arst_n = 1'b0;
		start = 1'b0;
		{first_x, first_y, second_x, second_y, third_x, third_y} = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed
		send(0, 0, 0, 0, 0, 0);
		send(256, 256, 256, 256, 256, 256);
		send(0, 0, 256, 256, 512, 512);
		send(mn, mn, 0, 0, mx, mx);
		send(0, 0, 256, 0, 0, 256);
		send(0, 0, 768, 0, 0, 1024);
		send(0, 0, 1, 0, 0, 1);
		send(mn, mn, mx, mn, mn, mx);
		send(mx, mx, mn, mx, mx, mn);
		send(mn, mn, mx, mx, mx, mx - 1);
		send(mn, 0, mx, 0, 0, 1);
		send(mn, 0, mx, 0, 0, mx);
		send(-256, -256, 256, -256, 0, 443);
		send(mx, 0, mn, 0, mx, 1);
		send(0, mn, 0, mx, 1, 0);
		send(mx, mx, mx, mx, mn, mn);
		send(100, 200, -300, 400, 500, -600);
		pause(3);

		k = 0;
		while (k < N_RANDOM) begin
			mode = $urandom_range(0, 9);
			burst = $urandom_range(0, 9) == 0 ? 40 : 1;
			repeat (burst) begin
				case (mode)
					0, 1, 2: send($urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom);
					3, 4, 5: send(small_coord(), small_coord(), small_coord(),
						small_coord(), small_coord(), small_coord());
					6: begin
						ax = $urandom; ay = $urandom;
						dx = small_coord(); dy = small_coord();
						m = $urandom_range(0, 6) - 3;
						send(ax, ay, ax + dx, ay + dy, ax + m * dx, ay + m * dy);
					end
					7: begin
						ax = small_coord(); ay = small_coord();
						send(ax, ay, ax, ay, ax + $urandom_range(0, 2),
							ay + $urandom_range(0, 2));
					end
					8: begin
						ax = $urandom;
						send(mn + $urandom_range(0, 3), ax, mx - $urandom_range(0, 3),
							ax + $urandom_range(0, 3), ax, ax + $urandom_range(0, 2));
					end
					default: send($urandom, $urandom, small_coord(), small_coord(),
						$urandom, $urandom);
				endcase
				k++;
			end
			pause(gap_len());
		end
		pause(1);

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

>>> files.f
design/ccc_pkg.sv
design/ccc_front.sv
design/ccc_mul.sv
design/ccc_isqrt.sv
design/ccc_div.sv
design/circumcircle_circumference_top.sv
test/tb.sv
